// ----- src/kvm_pkg.sv -----
// shared types and constants for the key/value map table
// used by kvm_cell and key_value_map_table; no dependencies
package kvm_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned TOTAL_W   = 5;
  localparam int unsigned TOTAL_MAX = 31;
  localparam int unsigned IN_W      = 72;
  localparam int unsigned OUT_W     = 40;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_t;

  // request moving down the row of cells, one cell per cycle
  typedef struct packed {
    logic                    active;
    cmd_t                    cmd;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
    logic                    hit;
    logic signed [VAL_W-1:0] found;
    logic                    free_seen;
  } token_t;

  // update broadcast to every cell once the scan is over
  typedef struct packed {
    logic                    en;
    cmd_t                    cmd;
    logic                    hit;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } commit_t;

endpackage

// ----- src/kvm_cell.sv -----
// one slot of the map: stored key, value and valid bit
// compares the passing request and applies the broadcast update; uses kvm_pkg
module kvm_cell
  import kvm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  token_t  tok_in,
  output token_t  tok_out,
  input  commit_t commit
);

  logic                    valid;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;
  logic                    mark_match;
  logic                    mark_free;
  logic                    match;

  assign match = valid && (key == tok_in.key);

  always_ff @(posedge clk) begin
    // control state
    if (rst) begin
      tok_out.active <= 1'b0;
      valid          <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
      if (commit.en) begin
        if (commit.cmd == CMD_ADD && !commit.hit && mark_free) begin
          valid <= 1'b1;
        end else if (commit.cmd == CMD_REMOVE && commit.hit && mark_match) begin
          valid <= 1'b0;
        end
      end
    end

    // payload, no reset
    tok_out.cmd       <= tok_in.cmd;
    tok_out.key       <= tok_in.key;
    tok_out.value     <= tok_in.value;
    tok_out.hit       <= tok_in.hit | match;
    tok_out.found     <= match ? value : tok_in.found;
    tok_out.free_seen <= tok_in.free_seen | !valid;
    if (tok_in.active) begin
      mark_match <= match;
      mark_free  <= !valid && !tok_in.free_seen;
    end
    if (commit.en && commit.cmd == CMD_ADD) begin
      if (commit.hit && mark_match) begin
        value <= commit.value;
      end else if (!commit.hit && mark_free) begin
        key   <= commit.key;
        value <= commit.value;
      end
    end
  end

endmodule

// ----- src/key_value_map_table.sv -----
// top level of the key/value map table: request entry, row of kvm_cell slots,
// update broadcast and result register; uses kvm_pkg and kvm_cell
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | command, key, new_value
//  m_*     | out | m_tvalid/m_tready  | result_value, hit, table_full, entry_total, is_empty
//
// a command walks the row of cells one slot per cycle, its outcome is parked, and
// then the update is broadcast and the result loaded once the output register is free
// one command is in flight at a time; s_tready is high only while idle
// a stalled result holds in the output register; the next command may be accepted
// and is parked after its scan until the output register frees up
// rst is synchronous and clears all valid bits and the entry count
module key_value_map_table
  import kvm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command[1:0], key[33:2], new_value[65:34], zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // result_value[31:0], hit[32], table_full[33],
                                      // entry_total[38:34], is_empty[39]
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t           state;
  token_t           pend;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  token_t  tok [ENTRIES+1];
  commit_t commit;

  logic                    accept;
  logic                    out_free;
  logic                    is_add;
  logic                    is_remove;
  logic                    is_status;
  logic                    res_hit;
  logic                    res_full;
  logic signed [VAL_W-1:0] res_value;
  logic [TOTAL_W-1:0]      res_total;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // request entering the first cell
  always_comb begin
    tok[0].active    = accept;
    tok[0].cmd       = cmd_t'(s_tdata[1:0]);
    tok[0].key       = s_tdata[33:2];
    tok[0].value     = s_tdata[65:34];
    tok[0].hit       = 1'b0;
    tok[0].found     = '0;
    tok[0].free_seen = 1'b0;
  end

  // row of slots, each handing the request to its neighbor
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .commit  (commit)
    );
  end

  // update broadcast and result fields from the parked scan outcome
  always_comb begin
    is_add    = (pend.cmd == CMD_ADD);
    is_remove = (pend.cmd == CMD_REMOVE);
    is_status = (pend.cmd == CMD_STATUS);

    commit.en    = (state == ST_DONE) && out_free;
    commit.cmd   = pend.cmd;
    commit.hit   = pend.hit;
    commit.key   = pend.key;
    commit.value = pend.value;

    res_hit   = pend.hit && !is_status;
    res_value = res_hit ? pend.found : '0;
    res_full  = is_add && !pend.hit && !pend.free_seen;

    count_next = count;
    if (is_add && !pend.hit && pend.free_seen) begin
      count_next = count + CNT_W'(1);
    end else if (is_remove && pend.hit) begin
      count_next = count - CNT_W'(1);
    end

    // entry_total saturates for deep tables
    if (32'(count_next) > TOTAL_MAX) begin
      res_total = TOTAL_W'(TOTAL_MAX);
    end else begin
      res_total = TOTAL_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
    end else begin
      // a result transfer empties the output register unless a new result loads it
      if (m_tvalid && m_tready && !commit.en) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // request leaves the last cell
          if (tok[ENTRIES].active) begin
            pend  <= tok[ENTRIES];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            count    <= count_next;
            m_tvalid <= 1'b1;
            m_tdata  <= {(count_next == '0), res_total, res_full, res_hit, res_value};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a request only leaves the row while a scan is running
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[ENTRIES].active |-> state == ST_SCAN)
    else $error("request left the cell row outside a scan");

  // no new request enters while one is in the row
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !tok[0].active)
    else $error("second request entered during a scan");

  // stored pair count never passes the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= ENTRIES)
    else $error("entry count exceeds slot count");

  // a dropped add is only reported when every slot is taken
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[33]) |-> 32'(count) == ENTRIES)
    else $error("table_full reported with free slots");

  // an update broadcast always loads a result
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit.en |=> m_tvalid)
    else $error("update without a result");
`endif

endmodule
